### src/scdm_pkg.sv
// ----------------------------------------------------------------------------
// scdm_pkg
// Shared widths, types and codes of the surround channel downmix core.
// ----------------------------------------------------------------------------
package scdm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;

  localparam int NUM_IN    = 8;
  localparam int NUM_OUT   = 4;
  localparam int NUM_LANE  = 5;
  localparam int NUM_PAIR  = 3;
  localparam int NUM_STAGE = 5;

  localparam int GAIN_FIELD = (GAIN_BITS < 16) ? GAIN_BITS : 16;
  localparam int GAIN_FRAC  = GAIN_BITS - 2;
  localparam int OPND_W     = SAMPLE_BITS + 2;
  localparam int PROD_W     = OPND_W + GAIN_FIELD;
  localparam int ACC_W      = PROD_W + 3;
  localparam int QUOT_W     = (ACC_W - GAIN_FRAC > SAMPLE_BITS) ?
                              (ACC_W - GAIN_FRAC) : (SAMPLE_BITS + 1);

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int MODE_W      = 4;
  localparam int USED_W      = 3;
  localparam int IN_TDATA_W  = ((NUM_IN * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_OUT * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = USED_W + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OPND_W-1:0]      opnd_t;
  typedef logic signed [GAIN_FIELD-1:0]  gain_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [QUOT_W-1:0]      quot_t;
  typedef logic [USED_W-1:0]             used_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SILENCE        = 4'd0,
    MODE_MONO_STEREO    = 4'd1,
    MODE_STEREO_MONO    = 4'd2,
    MODE_STEREO_MONO_EQ = 4'd3,
    MODE_QUAD_MONO      = 4'd4,
    MODE_QUAD_MONO_EQ   = 4'd5,
    MODE_STEREO_QUAD    = 4'd6,
    MODE_31_TO_2        = 4'd7,
    MODE_51_TO_2        = 4'd8,
    MODE_51_TO_31       = 4'd9,
    MODE_51_TO_4        = 4'd10,
    MODE_71_TO_2        = 4'd11,
    MODE_71_TO_31       = 4'd12,
    MODE_71_TO_4        = 4'd13
  } layout_mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LAYOUT_MODE  = 3'd0,
    REG_GAINS_FRONT  = 3'd1,
    REG_GAINS_CENTER = 3'd2,
    REG_GAINS_SIDE   = 3'd3,
    REG_GAINS_REAR   = 3'd4
  } cfg_reg_t;

  localparam acc_t  RND_HALF = acc_t'(1) << (GAIN_FRAC - 1);
  localparam quot_t Q_MAX    = quot_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam quot_t Q_MIN    = ~Q_MAX;

endpackage

### src/surround_channel_downmix_core.sv
// ----------------------------------------------------------------------------
// surround_channel_downmix_core
// Mixes one frame of eight surround samples into up to four output channels
// through a mode-selected gain matrix, with rounding and saturation.
// ----------------------------------------------------------------------------
//  channel  | ports                               | payload
//  ---------+-------------------------------------+---------------------------
//  input    | in_tvalid/in_tready/in_tdata/tlast  | 8 samples, block end
//  output   | out_tvalid/out_tready/out_tdata/... | 4 mixes, used, sat, end
//  config   | cfg_wr_en/cfg_addr/cfg_wdata        | mode, four gain pairs
//
// One frame per cycle unless the output stalls; five register stages
// (select/pre-add, multiply, pair add, final add with rounding bias, shift and
// clamp). rst_n clears the config registers and stage valids. Each stage holds
// while the next one is full and stalled; bubbles close up, and the last stage
// is the output register.
// ----------------------------------------------------------------------------
module surround_channel_downmix_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [scdm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [scdm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // front_left, front_right, center, lfe, side_left, side_right,
  // rear_left, rear_right
  input  logic [scdm_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // mix_out0, mix_out1, mix_out2, mix_out3
  output logic [scdm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // outputs_used, saturated
  output logic [scdm_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                 out_tlast
);

  localparam int SB = scdm_pkg::SAMPLE_BITS;
  localparam int NS = scdm_pkg::NUM_STAGE;

  // config registers
  logic [scdm_pkg::MODE_W-1:0]     mode_r;
  logic [scdm_pkg::CFG_DATA_W-1:0] gains_front_r;
  logic [scdm_pkg::CFG_DATA_W-1:0] gains_center_r;
  logic [scdm_pkg::CFG_DATA_W-1:0] gains_side_r;
  logic [scdm_pkg::CFG_DATA_W-1:0] gains_rear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= '0;
      gains_front_r  <= '0;
      gains_center_r <= '0;
      gains_side_r   <= '0;
      gains_rear_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        scdm_pkg::REG_LAYOUT_MODE:  mode_r <= cfg_wdata[scdm_pkg::MODE_W-1:0];
        scdm_pkg::REG_GAINS_FRONT:  gains_front_r  <= cfg_wdata;
        scdm_pkg::REG_GAINS_CENTER: gains_center_r <= cfg_wdata;
        scdm_pkg::REG_GAINS_SIDE:   gains_side_r   <= cfg_wdata;
        scdm_pkg::REG_GAINS_REAR:   gains_rear_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  scdm_pkg::gain_t g_fl, g_fr, g_c, g_lfe, g_sl, g_sr, g_rl, g_rr;
  localparam int GF = scdm_pkg::GAIN_FIELD;

  assign g_fl  = $signed(gains_front_r [GF-1:0]);
  assign g_fr  = $signed(gains_front_r [16 +: GF]);
  assign g_c   = $signed(gains_center_r[GF-1:0]);
  assign g_lfe = $signed(gains_center_r[16 +: GF]);
  assign g_sl  = $signed(gains_side_r  [GF-1:0]);
  assign g_sr  = $signed(gains_side_r  [16 +: GF]);
  assign g_rl  = $signed(gains_rear_r  [GF-1:0]);
  assign g_rr  = $signed(gains_rear_r  [16 +: GF]);

  // stage handshake
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  logic                  last_r [NS];
  scdm_pkg::used_t       used_r [NS];

  // stage 1: operand routing and pre-add
  scdm_pkg::opnd_t x [scdm_pkg::NUM_IN];

  always_comb begin
    for (int i = 0; i < scdm_pkg::NUM_IN; i++) begin
      x[i] = scdm_pkg::opnd_t'($signed(in_tdata[i*SB +: SB]));
    end
  end

  scdm_pkg::opnd_t opa_nxt  [scdm_pkg::NUM_OUT][scdm_pkg::NUM_LANE];
  scdm_pkg::gain_t gn_nxt   [scdm_pkg::NUM_OUT][scdm_pkg::NUM_LANE];
  scdm_pkg::used_t used_nxt;

  always_comb begin
    for (int c = 0; c < scdm_pkg::NUM_OUT; c++) begin
      for (int l = 0; l < scdm_pkg::NUM_LANE; l++) begin
        opa_nxt[c][l] = '0;
        gn_nxt[c][l]  = '0;
      end
    end
    used_nxt = '0;
    unique case (mode_r) inside
      scdm_pkg::MODE_MONO_STEREO: begin
        opa_nxt[0][0] = x[0]; gn_nxt[0][0] = g_fl;
        opa_nxt[1][0] = x[0]; gn_nxt[1][0] = g_fr;
        used_nxt = 3'd2;
      end
      scdm_pkg::MODE_STEREO_MONO: begin
        opa_nxt[0][0] = x[0]; gn_nxt[0][0] = g_fl;
        opa_nxt[0][1] = x[1]; gn_nxt[0][1] = g_fr;
        used_nxt = 3'd1;
      end
      scdm_pkg::MODE_STEREO_MONO_EQ: begin
        opa_nxt[0][0] = x[0] + x[1]; gn_nxt[0][0] = g_fl;
        used_nxt = 3'd1;
      end
      scdm_pkg::MODE_QUAD_MONO: begin
        opa_nxt[0][0] = x[0]; gn_nxt[0][0] = g_fl;
        opa_nxt[0][1] = x[1]; gn_nxt[0][1] = g_fr;
        opa_nxt[0][2] = x[2]; gn_nxt[0][2] = g_rl;
        opa_nxt[0][3] = x[3]; gn_nxt[0][3] = g_rr;
        used_nxt = 3'd1;
      end
      scdm_pkg::MODE_QUAD_MONO_EQ: begin
        opa_nxt[0][0] = x[0] + x[1] + x[2] + x[3]; gn_nxt[0][0] = g_fl;
        used_nxt = 3'd1;
      end
      scdm_pkg::MODE_STEREO_QUAD: begin
        opa_nxt[0][0] = x[0]; gn_nxt[0][0] = g_fl;
        opa_nxt[1][0] = x[1]; gn_nxt[1][0] = g_fr;
        opa_nxt[2][0] = x[0]; gn_nxt[2][0] = g_rl;
        opa_nxt[3][0] = x[1]; gn_nxt[3][0] = g_rr;
        used_nxt = 3'd4;
      end
      scdm_pkg::MODE_31_TO_2, scdm_pkg::MODE_51_TO_2, scdm_pkg::MODE_51_TO_4,
      scdm_pkg::MODE_71_TO_2, scdm_pkg::MODE_71_TO_4: begin
        // front plus center/lfe on both front outputs
        opa_nxt[0][0] = x[0]; gn_nxt[0][0] = g_fl;
        opa_nxt[0][1] = x[2]; gn_nxt[0][1] = g_c;
        opa_nxt[0][2] = x[3]; gn_nxt[0][2] = g_lfe;
        opa_nxt[1][0] = x[1]; gn_nxt[1][0] = g_fr;
        opa_nxt[1][1] = x[2]; gn_nxt[1][1] = g_c;
        opa_nxt[1][2] = x[3]; gn_nxt[1][2] = g_lfe;
        used_nxt = 3'd2;
        if (mode_r == scdm_pkg::MODE_51_TO_4) begin
          opa_nxt[2][0] = x[4]; gn_nxt[2][0] = g_sl;
          opa_nxt[3][0] = x[5]; gn_nxt[3][0] = g_sr;
          used_nxt = 3'd4;
        end
        if (mode_r == scdm_pkg::MODE_51_TO_2 || mode_r == scdm_pkg::MODE_71_TO_2 ||
            mode_r == scdm_pkg::MODE_71_TO_4) begin
          opa_nxt[0][3] = x[4]; gn_nxt[0][3] = g_sl;
          opa_nxt[1][3] = x[5]; gn_nxt[1][3] = g_sr;
        end
        if (mode_r == scdm_pkg::MODE_71_TO_2) begin
          opa_nxt[0][4] = x[6]; gn_nxt[0][4] = g_rl;
          opa_nxt[1][4] = x[7]; gn_nxt[1][4] = g_rr;
        end
        if (mode_r == scdm_pkg::MODE_71_TO_4) begin
          opa_nxt[2][0] = x[6]; gn_nxt[2][0] = g_rl;
          opa_nxt[2][1] = x[4]; gn_nxt[2][1] = g_sl;
          opa_nxt[3][0] = x[7]; gn_nxt[3][0] = g_rr;
          opa_nxt[3][1] = x[5]; gn_nxt[3][1] = g_sr;
          used_nxt = 3'd4;
        end
      end
      scdm_pkg::MODE_51_TO_31: begin
        opa_nxt[0][0] = x[0]; gn_nxt[0][0] = g_fl;
        opa_nxt[0][1] = x[4]; gn_nxt[0][1] = g_sl;
        opa_nxt[1][0] = x[1]; gn_nxt[1][0] = g_fr;
        opa_nxt[1][1] = x[5]; gn_nxt[1][1] = g_sr;
        opa_nxt[2][0] = x[2]; gn_nxt[2][0] = g_c;
        opa_nxt[3][0] = x[3]; gn_nxt[3][0] = g_lfe;
        used_nxt = 3'd4;
      end
      scdm_pkg::MODE_71_TO_31: begin
        opa_nxt[0][0] = x[0];        gn_nxt[0][0] = g_fl;
        opa_nxt[0][1] = x[4] + x[6]; gn_nxt[0][1] = g_sl;
        opa_nxt[1][0] = x[1];        gn_nxt[1][0] = g_fr;
        opa_nxt[1][1] = x[5] + x[7]; gn_nxt[1][1] = g_sr;
        opa_nxt[2][0] = x[2];        gn_nxt[2][0] = g_c;
        opa_nxt[3][0] = x[3];        gn_nxt[3][0] = g_lfe;
        used_nxt = 3'd4;
      end
      default: ;  // silence and unused codes: all lanes zero
    endcase
  end

  scdm_pkg::opnd_t s1_opa_r [scdm_pkg::NUM_OUT][scdm_pkg::NUM_LANE];
  scdm_pkg::gain_t s1_gn_r  [scdm_pkg::NUM_OUT][scdm_pkg::NUM_LANE];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_opa_r  <= opa_nxt;
      s1_gn_r   <= gn_nxt;
      last_r[0] <= in_tlast;
      used_r[0] <= used_nxt;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        last_r[k] <= last_r[k-1];
        used_r[k] <= used_r[k-1];
      end
    end
  end

  // stage 2: lane products
  scdm_pkg::prod_t s2_prod_r [scdm_pkg::NUM_OUT][scdm_pkg::NUM_LANE];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int c = 0; c < scdm_pkg::NUM_OUT; c++) begin
        for (int l = 0; l < scdm_pkg::NUM_LANE; l++) begin
          s2_prod_r[c][l] <= scdm_pkg::prod_t'(s1_opa_r[c][l]) *
                             scdm_pkg::prod_t'(s1_gn_r[c][l]);
        end
      end
    end
  end

  // stage 3: pair sums
  scdm_pkg::acc_t s3_pair_r [scdm_pkg::NUM_OUT][scdm_pkg::NUM_PAIR];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int c = 0; c < scdm_pkg::NUM_OUT; c++) begin
        s3_pair_r[c][0] <= scdm_pkg::acc_t'(s2_prod_r[c][0]) +
                           scdm_pkg::acc_t'(s2_prod_r[c][1]);
        s3_pair_r[c][1] <= scdm_pkg::acc_t'(s2_prod_r[c][2]) +
                           scdm_pkg::acc_t'(s2_prod_r[c][3]);
        s3_pair_r[c][2] <= scdm_pkg::acc_t'(s2_prod_r[c][4]);
      end
    end
  end

  // stage 4: total plus rounding bias
  scdm_pkg::acc_t s4_sum_r [scdm_pkg::NUM_OUT];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int c = 0; c < scdm_pkg::NUM_OUT; c++) begin
        s4_sum_r[c] <= s3_pair_r[c][0] + s3_pair_r[c][1] + s3_pair_r[c][2] +
                       scdm_pkg::RND_HALF;
      end
    end
  end

  // stage 5: floor shift and clamp (output register)
  scdm_pkg::quot_t  quo [scdm_pkg::NUM_OUT];
  scdm_pkg::sample_t mix_nxt [scdm_pkg::NUM_OUT];
  logic             sat_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int c = 0; c < scdm_pkg::NUM_OUT; c++) begin
      quo[c] = scdm_pkg::quot_t'(s4_sum_r[c] >>> scdm_pkg::GAIN_FRAC);
      if (quo[c] > scdm_pkg::Q_MAX) begin
        mix_nxt[c] = scdm_pkg::sample_t'(scdm_pkg::Q_MAX);
        sat_nxt    = 1'b1;
      end else if (quo[c] < scdm_pkg::Q_MIN) begin
        mix_nxt[c] = scdm_pkg::sample_t'(scdm_pkg::Q_MIN);
        sat_nxt    = 1'b1;
      end else begin
        mix_nxt[c] = scdm_pkg::sample_t'(quo[c]);
      end
    end
  end

  scdm_pkg::sample_t s5_mix_r [scdm_pkg::NUM_OUT];
  logic              s5_sat_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_mix_r <= mix_nxt;
      s5_sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = vld_r[NS-1];
  assign out_tlast  = last_r[NS-1];
  assign out_tuser  = {s5_sat_r, used_r[NS-1]};
  assign out_tdata  = scdm_pkg::OUT_TDATA_W'({s5_mix_r[3], s5_mix_r[2],
                                              s5_mix_r[1], s5_mix_r[0]});

  // checks
  localparam scdm_pkg::sample_t S_MAX = scdm_pkg::sample_t'(scdm_pkg::Q_MAX);
  localparam scdm_pkg::sample_t S_MIN = scdm_pkg::sample_t'(scdm_pkg::Q_MIN);

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && used_r[NS-1] < 3'd4) |->
      (s5_mix_r[2] == '0 && s5_mix_r[3] == '0))
    else $error("unused output channel not zero");

  a_silence_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && used_r[NS-1] == '0) |-> (!s5_sat_r && s5_mix_r[0] == '0))
    else $error("silent frame carries data or clip flag");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && s5_sat_r) |->
      (s5_mix_r[0] == S_MAX || s5_mix_r[0] == S_MIN ||
       s5_mix_r[1] == S_MAX || s5_mix_r[1] == S_MIN ||
       s5_mix_r[2] == S_MAX || s5_mix_r[2] == S_MIN ||
       s5_mix_r[3] == S_MAX || s5_mix_r[3] == S_MIN))
    else $error("clip flag without a clamped channel");

  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_tready) |-> (!in_tready ##1 (&vld_r)))
    else $error("full pipeline took a request or dropped a frame");

endmodule
